### design/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Input item kinds
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_EXPLORE = 1'b1;

  // Event kinds on the result stream
  typedef enum logic [1:0] {
    KIND_ENTER  = 2'd0,
    KIND_TREE   = 2'd1,
    KIND_BACK   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted input item
    logic add;         // set an edge in both directions
    logic reject;      // emit rejected-start event
    logic begin_walk;  // seed stack and visited marks, emit enter of start
    logic tree;        // emit tree edge to the found neighbor, hold it
    logic enter;       // push held neighbor, mark it, emit enter
    logic back;        // pop the top node, emit backtrack
  } dfs_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_explore;
    logic start_bad;
    logic found;
    logic depth_one;
    logic out_free;
  } dfs_stat_t;

endpackage

`default_nettype wire

### design/dfs_graph_traversal.sv
`default_nettype none

// Depth-first search over an undirected adjacency bit matrix.
// Input stream (s_*): one item per transfer. s_tuser is the command
// (add edge or explore), s_tdata carries the two node numbers.
// Output stream (m_*): one transfer per event (enter, tree edge,
// backtrack, rejected start); m_tlast marks the final event of an
// exploration. Add items produce no output.
// cfg_wr_en/cfg_wr_data write the node count (0 acts as 1, values above
// the node limit act as the limit).
// An explore item emits the enter of its start node, then a tree edge
// and an enter per further reached node and a backtrack per reached
// node; a rejected start emits only a reject event. One event register
// feeds the output, so the walk advances one event per cycle; a new item
// is taken only after the previous walk has ended.
// When m_tready is low the walk holds until the pending event is taken.
// Reset clears the edge matrix, the visited marks and the stack depth, and
// sets the node count to the limit; s_tready rises once reset is released.

module dfs_graph_traversal
  import dfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // node_a [3:0], node_b [7:4]
  input  wire logic [0:0]       s_tuser,   // cmd [0]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // node [3:0], from_node [7:4]
  output logic [1:0]            m_tuser,   // kind [1:0]
  output logic                  m_tlast
);

  dfs_ctrl_t ctrl;
  dfs_stat_t stat;
  kind_t     out_kind;
  node_t     out_node;
  node_t     out_from;

  dfs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dfs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (s_tuser[0]),
    .in_node_a   (s_tdata[3:0]),
    .in_node_b   (s_tdata[7:4]),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_node    (out_node),
    .out_from    (out_from),
    .out_last    (m_tlast)
  );

  // Pack the event fields
  assign m_tdata = {out_from, out_node};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

### design/dfs_datapath.sv
`default_nettype none

module dfs_datapath
  import dfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic        in_cmd,
  input  wire node_t       in_node_a,
  input  wire node_t       in_node_b,
  input  wire dfs_ctrl_t   ctrl,
  output dfs_stat_t        stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output kind_t            out_kind,
  output node_t            out_node,
  output node_t            out_from,
  output logic             out_last
);

  logic                 cmd_q;
  node_t                node_a;
  node_t                node_b;
  cnt_t                 num_nodes;
  logic [MAX_NODES-1:0] adj [MAX_NODES];
  logic [MAX_NODES-1:0] visited;
  node_t                stack [MAX_NODES];
  cnt_t                 depth;
  node_t                nxt;

  node_t                top;
  node_t                cur;
  logic                 a_ok;
  logic                 b_ok;
  logic [MAX_NODES-1:0] live;
  logic [MAX_NODES-1:0] cand;
  node_t                pick;
  logic                 emit;
  logic                 out_free;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= in_cmd;
      node_a <= in_node_a;
      node_b <= in_node_b;
    end
  end

  // Node count register, clamped to 1..MAX_NODES
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= cnt_t'(MAX_NODES);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        num_nodes <= cnt_t'(1);
      end else if (cfg_wr_data > cnt_t'(MAX_NODES)) begin
        num_nodes <= cnt_t'(MAX_NODES);
      end else begin
        num_nodes <= cfg_wr_data;
      end
    end
  end

  assign a_ok = {1'b0, node_a} < num_nodes;
  assign b_ok = {1'b0, node_b} < num_nodes;

  // Adjacency matrix, one row per node
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        adj[i] <= '0;
      end
    end else if (ctrl.add && a_ok && b_ok) begin
      adj[node_a][node_b] <= 1'b1;
      adj[node_b][node_a] <= 1'b1;
    end
  end

  // Top of stack and candidate neighbors
  assign top = depth[NODE_W-1:0] - node_t'(1);
  assign cur = stack[top];

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      live[i] = cnt_t'(i) < num_nodes;
    end
  end

  assign cand = adj[cur] & ~visited & live;

  // Lowest unvisited neighbor
  always_comb begin
    pick = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = node_t'(i);
      end
    end
  end

  // Stack of nodes on the current path
  always_ff @(posedge clk) begin
    if (ctrl.begin_walk) begin
      stack[0] <= node_a;
    end else if (ctrl.enter) begin
      stack[depth[NODE_W-1:0]] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctrl.begin_walk) begin
      depth <= cnt_t'(1);
    end else if (ctrl.enter) begin
      depth <= depth + cnt_t'(1);
    end else if (ctrl.back) begin
      depth <= depth - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (ctrl.begin_walk) begin
      visited <= MAX_NODES'(1) << node_a;
    end else if (ctrl.enter) begin
      visited <= visited | (MAX_NODES'(1) << nxt);
    end
  end

  // Hold the neighbor between tree-edge and enter events
  always_ff @(posedge clk) begin
    if (ctrl.tree) begin
      nxt <= pick;
    end
  end

  // Event output register
  assign emit     = ctrl.reject | ctrl.begin_walk | ctrl.tree | ctrl.enter | ctrl.back;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_from <= '0;
      out_last <= 1'b0;
      if (ctrl.reject) begin
        out_kind <= KIND_REJECT;
        out_node <= node_a;
        out_last <= 1'b1;
      end else if (ctrl.begin_walk) begin
        out_kind <= KIND_ENTER;
        out_node <= node_a;
      end else if (ctrl.tree) begin
        out_kind <= KIND_TREE;
        out_node <= pick;
        out_from <= cur;
      end else if (ctrl.enter) begin
        out_kind <= KIND_ENTER;
        out_node <= nxt;
      end else begin
        out_kind <= KIND_BACK;
        out_node <= cur;
        out_last <= depth == cnt_t'(1);
      end
    end
  end

  // Status to controller
  assign stat.is_explore = cmd_q == CMD_EXPLORE;
  assign stat.start_bad  = !a_ok;
  assign stat.found      = (|cand) && (depth < cnt_t'(MAX_NODES));
  assign stat.depth_one  = depth == cnt_t'(1);
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

### design/dfs_controller.sv
`default_nettype none

module dfs_controller
  import dfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dfs_stat_t stat,
  output dfs_ctrl_t      ctrl
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_SCAN  = 4'b0100,
    S_ENTER = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take no transfer while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  // Sequence one item: decode, then add, reject, or walk until the start is popped
  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctrl.load  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!stat.is_explore) begin
          ctrl.add   = 1'b1;
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          if (stat.start_bad) begin
            ctrl.reject = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ctrl.begin_walk = 1'b1;
            state_next      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          if (stat.found) begin
            ctrl.tree  = 1'b1;
            state_next = S_ENTER;
          end else begin
            ctrl.back = 1'b1;
            if (stat.depth_one) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_ENTER: begin
        if (stat.out_free) begin
          ctrl.enter = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sim/dfs_checker.sv
module dfs_checker
  import dfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [7:0]       s_tdata,   // node_a [3:0], node_b [7:4]
  input  wire logic [0:0]       s_tuser,   // cmd [0]
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [7:0]       m_tdata,   // node [3:0], from_node [7:4]
  input  wire logic [1:0]       m_tuser,   // kind [1:0]
  input  wire logic             m_tlast,
  output int                    pending,
  output int                    failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t kind;
    node_t node;
    node_t from_node;
    logic  last;
  } walk_event_t;

  // Shadow copy of the edge matrix and node count
  logic [MAX_NODES-1:0] edge_rows [MAX_NODES];
  int                   node_count;
  walk_event_t          expected_walk [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    failures++;
  endtask

  task automatic queue_event(input kind_t kind, input node_t node, input node_t from_node,
                             input logic last);
    walk_event_t ev;
    ev.kind      = kind;
    ev.node      = node;
    ev.from_node = from_node;
    ev.last      = last;
    expected_walk.push_back(ev);
  endtask

  // Walk the graph depth-first from start, lowest neighbor first, or reject a start past the count
  task automatic predict_walk(input node_t start);
    logic [MAX_NODES-1:0] seen;
    node_t                path_node [MAX_NODES];
    int                   path_next [MAX_NODES];
    int                   depth;
    int                   j;
    node_t                cur;
    logic                 hit;
    if (start >= node_count) begin
      queue_event(KIND_REJECT, start, '0, 1'b1);
    end else begin
      seen         = '0;
      seen[start]  = 1'b1;
      path_node[0] = start;
      path_next[0] = 0;
      depth        = 1;
      queue_event(KIND_ENTER, start, '0, 1'b0);
      while (depth > 0) begin
        cur = path_node[depth-1];
        j   = path_next[depth-1];
        hit = 1'b0;
        // a full stack has no further neighbor
        if (depth < MAX_NODES) begin
          while (j < node_count && !hit) begin
            if (edge_rows[cur][j] && !seen[j]) hit = 1'b1;
            else j++;
          end
        end
        if (hit) begin
          path_next[depth-1] = j + 1;
          queue_event(KIND_TREE, node_t'(j), cur, 1'b0);
          path_node[depth] = node_t'(j);
          path_next[depth] = 0;
          depth++;
          seen[j] = 1'b1;
          queue_event(KIND_ENTER, node_t'(j), '0, 1'b0);
        end else begin
          depth--;
          queue_event(KIND_BACK, cur, '0, depth == 0);
        end
      end
    end
  endtask

  // Track config writes, input transfers and output transfers
  always @(posedge clk) begin
    walk_event_t exp_ev;
    node_t       a;
    node_t       b;
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
      node_count = MAX_NODES;
      expected_walk.delete();
    end else begin
      if (cfg_wr_en) begin
        node_count = cfg_wr_data;
        if (node_count == 0) node_count = 1;
        if (node_count > MAX_NODES) node_count = MAX_NODES;
      end
      if (s_tvalid && s_tready) begin
        a = s_tdata[3:0];
        b = s_tdata[7:4];
        if (s_tuser[0] == CMD_EXPLORE) begin
          predict_walk(a);
        end else if (a < node_count && b < node_count) begin
          edge_rows[a][b] = 1'b1;
          edge_rows[b][a] = 1'b1;
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_walk.size() == 0) begin
          report_mismatch($sformatf("event with none expected: kind %0d node %0d from %0d last %0d",
                                    m_tuser, m_tdata[3:0], m_tdata[7:4], m_tlast));
        end else begin
          exp_ev = expected_walk.pop_front();
          if (m_tuser != exp_ev.kind)
            report_mismatch($sformatf("kind got %0d want %0d", m_tuser, exp_ev.kind));
          if (m_tdata[3:0] != exp_ev.node)
            report_mismatch($sformatf("node got %0d want %0d", m_tdata[3:0], exp_ev.node));
          if (m_tdata[7:4] != exp_ev.from_node)
            report_mismatch($sformatf("from_node got %0d want %0d", m_tdata[7:4],
                                      exp_ev.from_node));
          if (m_tlast != exp_ev.last)
            report_mismatch($sformatf("last got %0d want %0d", m_tlast, exp_ev.last));
        end
      end
    end
    pending <= expected_walk.size();
  end

endmodule

### sim/dfs_graph_traversal_tb.sv
module dfs_graph_traversal_tb;
  import dfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // node_a [3:0], node_b [7:4]
  logic [0:0]       s_tuser;   // cmd [0]
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;   // node [3:0], from_node [7:4]
  logic [1:0]       m_tuser;   // kind [1:0]
  logic             m_tlast;
  int               pending;
  int               failures;

  // Shared stimulus controls
  logic             no_gaps;
  logic             hold_req;
  int               nodes_in_use;

  dfs_graph_traversal i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  dfs_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .pending     (pending),
    .failures    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in burst phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(10, 30);
  endfunction

  // Mostly nodes that exist, sometimes any node number
  function automatic node_t pick_node();
    if ($urandom_range(0, 9) < 8) return node_t'($urandom_range(0, nodes_in_use - 1));
    else return node_t'($urandom_range(0, MAX_NODES - 1));
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic cmd, input node_t a, input node_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser[0] <= cmd;
    s_tdata    <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected event has been taken
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_count(input int value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    nodes_in_use = (value == 0) ? 1 : (value > MAX_NODES ? MAX_NODES : value);
  endtask

  // Result side: random ready pattern plus one long hold-off
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int phase_counts [7];
    int issued;
    int adds;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    no_gaps      = 1'b0;
    hold_req     = 1'b0;
    nodes_in_use = MAX_NODES;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty graph at full size
    send_item(CMD_EXPLORE, 4'd0, 4'd0);
    send_item(CMD_EXPLORE, 4'd15, 4'd9);
    // Edges at the extremes, a self loop, a small tree
    send_item(CMD_ADD, 4'd0, 4'd15);
    send_item(CMD_ADD, 4'd15, 4'd15);
    send_item(CMD_ADD, 4'd7, 4'd15);
    send_item(CMD_ADD, 4'd3, 4'd7);
    send_item(CMD_EXPLORE, 4'd15, 4'd0);
    send_item(CMD_EXPLORE, 4'd3, 4'd15);

    // Zero acts as a single node: others are rejected, edges ignored
    set_node_count(0);
    send_item(CMD_EXPLORE, 4'd0, 4'd0);
    send_item(CMD_EXPLORE, 4'd1, 4'd0);
    send_item(CMD_ADD, 4'd0, 4'd1);
    send_item(CMD_EXPLORE, 4'd15, 4'd15);

    // Shrunk graph keeps edges but never follows those past the count
    set_node_count(8);
    send_item(CMD_EXPLORE, 4'd7, 4'd0);
    send_item(CMD_ADD, 4'd8, 4'd2);
    send_item(CMD_ADD, 4'd2, 4'd8);
    send_item(CMD_EXPLORE, 4'd8, 4'd0);

    // Over-range count acts as the limit; a full chain fills the stack
    set_node_count(31);
    for (int i = 0; i < MAX_NODES - 1; i++) send_item(CMD_ADD, node_t'(i), node_t'(i + 1));
    send_item(CMD_EXPLORE, 4'd0, 4'd0);
    send_item(CMD_EXPLORE, 4'd8, 4'd0);

    // Random phases: runs of edges followed by an explore
    phase_counts = '{6, 16, 3, 31, 1, 11, 0};
    phase_counts[6] = $urandom_range(0, 31);
    for (int phase = 0; phase < 7; phase++) begin
      set_node_count(phase_counts[phase]);
      no_gaps = (phase == 1 || phase == 5);
      if (phase == 2) hold_req = 1'b1;
      issued = 0;
      while (issued < 16) begin
        adds = $urandom_range(0, 4);
        repeat (adds) send_item(CMD_ADD, pick_node(), pick_node());
        send_item(CMD_EXPLORE, pick_node(), node_t'($urandom_range(0, MAX_NODES - 1)));
        issued += adds + 1;
      end
    end

    no_gaps = 1'b0;
    wait_idle();
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
